@@ rtl/pcf_pkg.sv @@
`default_nettype none

package pcf_pkg;

	// Alphabet indices and square geometry
	localparam logic [4:0] LETTER_I = 5'd8;
	localparam logic [4:0] LETTER_J = 5'd9;
	localparam logic [4:0] LETTER_X = 5'd23;
	localparam logic [4:0] LETTER_Z = 5'd25;
	localparam logic [4:0] CELLS    = 5'd25;

	// Item operations
	typedef enum logic [1:0] {
		OP_KEY     = 2'd0,
		OP_FINISH  = 2'd1,
		OP_ENCRYPT = 2'd2,
		OP_DECRYPT = 2'd3
	} op_t;

	// Result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_READY = 2'd1;
	localparam logic [1:0] STATUS_ODD       = 2'd2;

	// Work passed from the front end to the back end
	typedef enum logic [1:0] {
		JOB_WRITE = 2'd0,
		JOB_PAIR  = 2'd1,
		JOB_ERR   = 2'd2
	} job_kind_t;

	// JOB_WRITE: a = letter, b = cell.  JOB_PAIR: digraph (a, b).
	// twice: map the pair two times, only the second ends the run.
	typedef struct packed {
		job_kind_t  kind;
		logic [4:0] a;
		logic [4:0] b;
		logic       fwd;
		logic       twice;
		logic [1:0] status;
	} job_t;

	typedef struct packed {
		logic [4:0] letter;
		logic [1:0] status;
		logic       last;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/pcf_fifo.sv @@
`default_nettype none

module pcf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [AW:0]      wr_ptr_q;
	logic [AW:0]      rd_ptr_q;

	assign empty   = (wr_ptr_q == rd_ptr_q);
	assign full    = (wr_ptr_q[AW] != rd_ptr_q[AW]) &&
	                 (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);
	assign rd_data = slots_q[rd_ptr_q[AW-1:0]];

	// Storage, no reset needed
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q[AW-1:0]] <= wr_data;
		end
	end

	// Pointers with wrap bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/pcf_front.sv @@
`default_nettype none

module pcf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [1:0]    operation,
	input  logic [4:0]    letter,
	input  logic          last_letter,
	output logic          job_push,
	output pcf_pkg::job_t job,
	input  logic          job_full
);

	logic [25:0] used_q, used_d;
	logic [4:0]  fill_q, fill_d;
	logic        ready_q, ready_d;
	logic [4:0]  held_q, held_d;
	logic        held_valid_q, held_valid_d;
	logic        walk_q, walk_d;
	logic [4:0]  idx_q, idx_d;

	logic [4:0]  sat_letter;
	logic [4:0]  c;
	logic        accept;
	logic        walk_place;
	logic        advance;

	// Busy during the alphabet walk; every item needs at most one job slot
	assign full   = walk_q | job_full;
	assign accept = push & ~full;

	// Clamp to Z, fold J onto I
	assign sat_letter = (letter > pcf_pkg::LETTER_Z) ? pcf_pkg::LETTER_Z : letter;
	assign c          = (sat_letter == pcf_pkg::LETTER_J) ? pcf_pkg::LETTER_I : sat_letter;

	assign walk_place = walk_q && (idx_q != pcf_pkg::LETTER_J) && !used_q[idx_q] &&
	                    (fill_q < pcf_pkg::CELLS);

	// Classification and key bookkeeping
	always_comb begin
		job_push     = 1'b0;
		job          = '0;
		job.kind     = pcf_pkg::JOB_PAIR;
		job.fwd      = 1'b1;
		job.status   = pcf_pkg::STATUS_OK;
		used_d       = used_q;
		fill_d       = fill_q;
		ready_d      = ready_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		walk_d       = walk_q;
		idx_d        = idx_q;
		advance      = 1'b0;

		if (walk_q) begin
			// Finish: one letter of the alphabet per cycle, holding while the job queue is full
			if (walk_place) begin
				if (!job_full) begin
					job_push       = 1'b1;
					job.kind       = pcf_pkg::JOB_WRITE;
					job.a          = idx_q;
					job.b          = fill_q;
					used_d[idx_q]  = 1'b1;
					fill_d         = fill_q + 5'd1;
					advance        = 1'b1;
				end
			end else begin
				advance = 1'b1;
			end
			if (advance) begin
				if (idx_q == pcf_pkg::LETTER_Z) begin
					walk_d  = 1'b0;
					ready_d = 1'b1;
				end else begin
					idx_d = idx_q + 5'd1;
				end
			end
		end else if (accept) begin
			unique case (pcf_pkg::op_t'(operation))
				pcf_pkg::OP_KEY: begin
					if (!ready_q && !used_q[c] && (fill_q < pcf_pkg::CELLS)) begin
						job_push   = 1'b1;
						job.kind   = pcf_pkg::JOB_WRITE;
						job.a      = c;
						job.b      = fill_q;
						used_d[c]  = 1'b1;
						fill_d     = fill_q + 5'd1;
					end
				end
				pcf_pkg::OP_FINISH: begin
					if (!ready_q) begin
						walk_d = 1'b1;
						idx_d  = '0;
					end
				end
				pcf_pkg::OP_ENCRYPT: begin
					if (!ready_q) begin
						job_push   = 1'b1;
						job.kind   = pcf_pkg::JOB_ERR;
						job.status = pcf_pkg::STATUS_NOT_READY;
					end else if (!held_valid_q) begin
						if (last_letter) begin
							job_push = 1'b1;
							job.a    = c;
							job.b    = pcf_pkg::LETTER_X;
						end else begin
							held_d       = c;
							held_valid_d = 1'b1;
						end
					end else if (held_q == c) begin
						// Doubled letter: pad with X, the repeat stays held unless it is the last letter, then the pair is mapped twice
						job_push = 1'b1;
						job.a    = c;
						job.b    = pcf_pkg::LETTER_X;
						if (last_letter) begin
							job.twice    = 1'b1;
							held_d       = '0;
							held_valid_d = 1'b0;
						end
					end else begin
						job_push     = 1'b1;
						job.a        = held_q;
						job.b        = c;
						held_d       = '0;
						held_valid_d = 1'b0;
					end
				end
				pcf_pkg::OP_DECRYPT: begin
					if (!ready_q) begin
						job_push   = 1'b1;
						job.kind   = pcf_pkg::JOB_ERR;
						job.status = pcf_pkg::STATUS_NOT_READY;
					end else if (!held_valid_q) begin
						if (last_letter) begin
							job_push   = 1'b1;
							job.kind   = pcf_pkg::JOB_ERR;
							job.status = pcf_pkg::STATUS_ODD;
						end else begin
							held_d       = c;
							held_valid_d = 1'b1;
						end
					end else begin
						job_push     = 1'b1;
						job.a        = held_q;
						job.b        = c;
						job.fwd      = 1'b0;
						held_d       = '0;
						held_valid_d = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			fill_q       <= '0;
			ready_q      <= 1'b0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			walk_q       <= 1'b0;
			idx_q        <= '0;
		end else begin
			used_q       <= used_d;
			fill_q       <= fill_d;
			ready_q      <= ready_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			walk_q       <= walk_d;
			idx_q        <= idx_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pcf_back.sv @@
`default_nettype none

module pcf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pcf_pkg::job_t    job,
	input  logic             job_empty,
	output logic             job_pop,
	output logic             res_push,
	output pcf_pkg::result_t res,
	input  logic             res_full
);

	typedef enum logic [3:0] {
		B_IDLE  = 4'b0001,
		B_POS   = 4'b0010,
		B_EMIT0 = 4'b0100,
		B_EMIT1 = 4'b1000
	} back_state_t;

	back_state_t state_q, state_d;

	logic [4:0] key_sq [25];
	logic [4:0] pos_mem [26];

	logic [4:0] pos_a_q, pos_b_q;
	logic [4:0] let_a_q, let_b_q;
	logic       fwd_q;
	logic       twice_q;
	logic [4:0] oa, ob;

	logic do_write, do_err, do_pair;

	function automatic logic [2:0] row_of(input logic [4:0] p);
		if (p < 5'd5) begin
			return 3'd0;
		end else if (p < 5'd10) begin
			return 3'd1;
		end else if (p < 5'd15) begin
			return 3'd2;
		end else if (p < 5'd20) begin
			return 3'd3;
		end
		return 3'd4;
	endfunction

	function automatic logic [4:0] base_of(input logic [2:0] r);
		return {r, 2'b00} + 5'(r);
	endfunction

	function automatic logic [2:0] step_of(input logic [2:0] x, input logic fwd);
		if (fwd) begin
			return (x == 3'd4) ? 3'd0 : x + 3'd1;
		end
		return (x == 3'd0) ? 3'd4 : x - 3'd1;
	endfunction

	// Digraph rules on cell numbers: same row, same column, rectangle
	function automatic logic [9:0] map_cells(input logic [4:0] pa, input logic [4:0] pb,
	                                         input logic fwd);
		logic [2:0] ra, ca, rb, cb;
		logic [4:0] na, nb;
		ra = row_of(pa);
		rb = row_of(pb);
		ca = 3'(pa - base_of(ra));
		cb = 3'(pb - base_of(rb));
		if (ra == rb) begin
			na = base_of(ra) + 5'(step_of(ca, fwd));
			nb = base_of(rb) + 5'(step_of(cb, fwd));
		end else if (ca == cb) begin
			na = base_of(step_of(ra, fwd)) + 5'(ca);
			nb = base_of(step_of(rb, fwd)) + 5'(cb);
		end else begin
			na = base_of(ra) + 5'(cb);
			nb = base_of(rb) + 5'(ca);
		end
		return {na, nb};
	endfunction

	assign {oa, ob} = map_cells(pos_a_q, pos_b_q, fwd_q);

	// Job dispatch from idle
	assign do_write = (state_q == B_IDLE) && !job_empty && (job.kind == pcf_pkg::JOB_WRITE);
	assign do_err   = (state_q == B_IDLE) && !job_empty && (job.kind == pcf_pkg::JOB_ERR) &&
	                  !res_full;
	assign do_pair  = (state_q == B_IDLE) && !job_empty && (job.kind == pcf_pkg::JOB_PAIR);
	assign job_pop  = do_write | do_err | do_pair;

	// Square and position memories, registered reads
	always_ff @(posedge clk) begin
		if (do_write) begin
			key_sq[job.b]  <= job.a;
			pos_mem[job.a] <= job.b;
		end
		if (do_pair) begin
			pos_a_q <= pos_mem[job.a];
			pos_b_q <= pos_mem[job.b];
			fwd_q   <= job.fwd;
		end
		if (state_q == B_POS) begin
			let_a_q <= key_sq[oa];
			let_b_q <= key_sq[ob];
		end
	end

	// Result generation and sequencing
	always_comb begin
		state_d    = state_q;
		res_push   = 1'b0;
		res.letter = '0;
		res.status = pcf_pkg::STATUS_OK;
		res.last   = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				if (do_err) begin
					res_push   = 1'b1;
					res.status = job.status;
					res.last   = 1'b1;
				end else if (do_pair) begin
					state_d = B_POS;
				end
			end
			B_POS: begin
				state_d = B_EMIT0;
			end
			B_EMIT0: begin
				if (!res_full) begin
					res_push   = 1'b1;
					res.letter = let_a_q;
					state_d    = B_EMIT1;
				end
			end
			B_EMIT1: begin
				if (!res_full) begin
					res_push   = 1'b1;
					res.letter = let_b_q;
					res.last   = !twice_q;
					state_d    = twice_q ? B_EMIT0 : B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			twice_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_pair) begin
				twice_q <= job.twice;
			end else if ((state_q == B_EMIT1) && !res_full) begin
				twice_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/playfair_cipher_engine.sv @@
// A text item's first result passes through the job queue, the back end's position
// and square lookups and the result queue. The back end takes one digraph at a time:
// two lookups, then one result per cycle while the result queue is not full; a doubled
// final letter repeats both results. Finishing the key walks the alphabet while busy.
// Reset clears all control state and queues; the square is undefined until filled.
`default_nettype none

module playfair_cipher_engine #(
	parameter int JOB_DEPTH = 2,
	parameter int RES_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] operation,
	input  logic [4:0] letter,
	input  logic       last_letter,
	output logic       empty,
	input  logic       pop,
	output logic [4:0] out_letter,
	output logic [1:0] status,
	output logic       end_of_run
);

	localparam int JOB_W = $bits(pcf_pkg::job_t);
	localparam int RES_W = $bits(pcf_pkg::result_t);

	pcf_pkg::job_t    job_wr, job_rd;
	logic [JOB_W-1:0] job_rd_bits;
	logic             job_push, job_full, job_pop, job_empty;

	pcf_pkg::result_t res_wr, res_rd;
	logic [RES_W-1:0] res_rd_bits;
	logic             res_push, res_full;

	pcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.operation  (operation),
		.letter     (letter),
		.last_letter(last_letter),
		.job_push   (job_push),
		.job        (job_wr),
		.job_full   (job_full)
	);

	pcf_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(JOB_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_data(job_wr),
		.full   (job_full),
		.rd_en  (job_pop),
		.rd_data(job_rd_bits),
		.empty  (job_empty)
	);

	assign job_rd = pcf_pkg::job_t'(job_rd_bits);

	pcf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job_rd),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.res_push (res_push),
		.res      (res_wr),
		.res_full (res_full)
	);

	pcf_fifo #(
		.WIDTH(RES_W),
		.DEPTH(RES_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_wr),
		.full   (res_full),
		.rd_en  (pop & ~empty),
		.rd_data(res_rd_bits),
		.empty  (empty)
	);

	assign res_rd     = pcf_pkg::result_t'(res_rd_bits);
	assign out_letter = res_rd.letter;
	assign status     = res_rd.status;
	assign end_of_run = res_rd.last;

endmodule

`default_nettype wire

@@ rtl/pcf_checker.sv @@
`default_nettype none

module pcf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic [1:0] operation,
	input logic [4:0] letter,
	input logic       last_letter,
	input logic       empty,
	input logic       pop,
	input logic [4:0] out_letter,
	input logic [1:0] status,
	input logic       end_of_run
);

	// Error transactions are single results with a zero letter
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != pcf_pkg::STATUS_OK) |-> (end_of_run && out_letter == 5'd0))
		else $error("error result not a lone zero letter");

	// The square never holds J and only holds alphabet letters
	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == pcf_pkg::STATUS_OK) |->
		(out_letter != pcf_pkg::LETTER_J && out_letter <= pcf_pkg::LETTER_Z))
		else $error("ciphered letter out of range");

	// A waiting result is not withdrawn
	a_res_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result dropped without pop");

	// A waiting result holds its value
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(out_letter) && $stable(status) && $stable(end_of_run)))
		else $error("result changed while waiting");

	// Fields of a taken transaction are known
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |-> !$isunknown({operation, letter, last_letter}))
		else $error("unknown fields on an accepted transaction");

endmodule

bind playfair_cipher_engine pcf_checker u_pcf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.operation  (operation),
	.letter     (letter),
	.last_letter(last_letter),
	.empty      (empty),
	.pop        (pop),
	.out_letter (out_letter),
	.status     (status),
	.end_of_run (end_of_run)
);

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [1:0] operation;
	logic [4:0] letter;
	logic       last_letter;
	logic       empty;
	logic       pop = 1'b0;
	logic [4:0] out_letter;
	logic [1:0] status;
	logic       end_of_run;

	playfair_cipher_engine dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.operation  (operation),
		.letter     (letter),
		.last_letter(last_letter),
		.empty      (empty),
		.pop        (pop),
		.out_letter (out_letter),
		.status     (status),
		.end_of_run (end_of_run)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Predicted cipher state
	logic [4:0] sq_letter [25];
	logic [4:0] sq_cell [26];
	bit         sq_used [26];
	int         sq_fill;
	bit         sq_ready;
	logic [4:0] hold_ltr;
	bit         hold_ok;

	// Cipher letters still owed by the block, oldest first
	pcf_pkg::result_t cipher_out_q [$];

	int  errors;
	int  text_items;
	int  burst_left;
	bit  no_gaps;
	int  hold_req;
	int  hold_left;
	int  rx_count;
	int  rx_mode;

	// Watchdog
	initial begin
		#1_000_000;
		$display("tb: failure");
		$finish;
	end

	// Append the next free cell of the square
	task automatic place_in_square(logic [4:0] c);
		if (!sq_used[c] && sq_fill < 25) begin
			sq_letter[sq_fill] = c;
			sq_cell[c] = 5'(sq_fill);
			sq_used[c] = 1'b1;
			sq_fill++;
		end
	endtask

	// Row, column or rectangle rule on one digraph; queues two letters
	task automatic expect_digraph(logic [4:0] a, logic [4:0] b, bit fwd, bit ends);
		int pa, pb, ra, ca, rb, cb, step, oa, ob;
		pcf_pkg::result_t r;
		pa = sq_cell[a];
		pb = sq_cell[b];
		ra = pa / 5;
		ca = pa % 5;
		rb = pb / 5;
		cb = pb % 5;
		step = fwd ? 1 : 4;
		if (ra == rb) begin
			oa = ra * 5 + (ca + step) % 5;
			ob = rb * 5 + (cb + step) % 5;
		end else if (ca == cb) begin
			oa = ((ra + step) % 5) * 5 + ca;
			ob = ((rb + step) % 5) * 5 + cb;
		end else begin
			oa = ra * 5 + cb;
			ob = rb * 5 + ca;
		end
		r.letter = sq_letter[oa];
		r.status = pcf_pkg::STATUS_OK;
		r.last = 1'b0;
		cipher_out_q.push_back(r);
		r.letter = sq_letter[ob];
		r.last = ends;
		cipher_out_q.push_back(r);
	endtask

	// Single error letter with the given status
	task automatic expect_error(logic [1:0] code);
		pcf_pkg::result_t r;
		r.letter = 5'd0;
		r.status = code;
		r.last = 1'b1;
		cipher_out_q.push_back(r);
	endtask

	// Advance the cipher state by one accepted item
	task automatic playfair_step(pcf_pkg::op_t op, logic [4:0] raw, bit fin);
		logic [4:0] c;
		int l;
		c = (raw > pcf_pkg::LETTER_Z) ? pcf_pkg::LETTER_Z : raw;
		if (c == pcf_pkg::LETTER_J)
			c = pcf_pkg::LETTER_I;
		case (op)
			pcf_pkg::OP_KEY: begin
				if (!sq_ready)
					place_in_square(c);
			end
			pcf_pkg::OP_FINISH: begin
				if (!sq_ready) begin
					for (l = 0; l <= 25; l++)
						if (l != pcf_pkg::LETTER_J)
							place_in_square(5'(l));
					sq_ready = 1'b1;
				end
			end
			default: begin
				if (!sq_ready) begin
					expect_error(pcf_pkg::STATUS_NOT_READY);
				end else if (op == pcf_pkg::OP_ENCRYPT) begin
					if (!hold_ok) begin
						if (fin) begin
							expect_digraph(c, pcf_pkg::LETTER_X, 1'b1, 1'b1);
						end else begin
							hold_ltr = c;
							hold_ok = 1'b1;
						end
					end else if (hold_ltr == c) begin
						// doubled letter: pad with X, keep the second one held unless it ends the message
						expect_digraph(hold_ltr, pcf_pkg::LETTER_X, 1'b1, !fin);
						if (fin) begin
							expect_digraph(c, pcf_pkg::LETTER_X, 1'b1, 1'b1);
							hold_ok = 1'b0;
							hold_ltr = 5'd0;
						end
					end else begin
						expect_digraph(hold_ltr, c, 1'b1, 1'b1);
						hold_ok = 1'b0;
						hold_ltr = 5'd0;
					end
				end else begin
					if (!hold_ok) begin
						if (fin) begin
							expect_error(pcf_pkg::STATUS_ODD);
						end else begin
							hold_ltr = c;
							hold_ok = 1'b1;
						end
					end else begin
						expect_digraph(hold_ltr, c, 1'b0, 1'b1);
						hold_ok = 1'b0;
						hold_ltr = 5'd0;
					end
				end
			end
		endcase
	endtask

	// Push one transaction; called and returns at a falling edge
	task automatic send_item(pcf_pkg::op_t op, logic [4:0] l, bit fin);
		// bursts of random length with random gaps
		if (!no_gaps) begin
			if (burst_left == 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 8);
			end else begin
				burst_left--;
			end
		end
		operation <= op;
		letter <= l;
		last_letter <= fin;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full !== 1'b0);
		playfair_step(op, l, fin);
		if (op == pcf_pkg::OP_ENCRYPT || op == pcf_pkg::OP_DECRYPT)
			text_items++;
		@(negedge clk);
	endtask

	// Text message with random letters and frequent doubled letters
	task automatic send_message(pcf_pkg::op_t op, int len);
		logic [4:0] prev, l;
		prev = 5'd0;
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(0, 4) == 0)
				l = prev;
			else if ($urandom_range(0, 7) == 0)
				l = 5'($urandom_range(0, 31));
			else
				l = 5'($urandom_range(0, 25));
			send_item(op, l, i == len - 1);
			prev = l;
		end
	endtask

	// Stop sending, let every owed letter arrive, then let the block settle
	task automatic wait_idle();
		push <= 1'b0;
		while (cipher_out_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver: randomly chosen stall patterns, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (rx_count % 50 == 0)
			rx_mode = $urandom_range(0, 3);
		rx_count++;
		if (hold_left != 0) begin
			pop <= 1'b0;
			hold_left--;
		end else begin
			case (rx_mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= (rx_count % 8) < 3;
			endcase
		end
	end

	// Result checker
	always @(posedge clk) begin
		pcf_pkg::result_t want;
		if (arst_n && pop && !empty) begin
			if (cipher_out_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: unexpected transaction letter %0d status %0d end %0d",
						$time, out_letter, status, end_of_run);
			end else begin
				want = cipher_out_q.pop_front();
				if (out_letter !== want.letter || status !== want.status ||
					end_of_run !== want.last) begin
					errors++;
					if (errors <= 10)
						$display("%0t: mismatch letter %0d/%0d status %0d/%0d end %0d/%0d (got/exp)",
							$time, out_letter, want.letter, status, want.status,
							end_of_run, want.last);
				end
			end
		end
	end

	// Text before the square exists
	task automatic test_not_ready();
		send_item(pcf_pkg::OP_ENCRYPT, 5'd31, 1'b0);
		send_item(pcf_pkg::OP_DECRYPT, 5'd0, 1'b1);
		send_item(pcf_pkg::OP_ENCRYPT, 5'd9, 1'b1);
	endtask

	// Key with J folding, out of range letters, duplicates, then finish
	task automatic test_key_build();
		int n;
		send_item(pcf_pkg::OP_KEY, pcf_pkg::LETTER_J, 1'b0);
		send_item(pcf_pkg::OP_KEY, pcf_pkg::LETTER_I, 1'b1);
		send_item(pcf_pkg::OP_KEY, 5'd31, 1'b0);
		send_item(pcf_pkg::OP_KEY, 5'd26, 1'b0);
		send_item(pcf_pkg::OP_KEY, 5'd0, 1'b0);
		n = $urandom_range(5, 40);
		repeat (n)
			send_item(pcf_pkg::OP_KEY, 5'($urandom_range(0, 31)),
				1'($urandom_range(0, 1)));
		send_item(pcf_pkg::OP_FINISH, 5'($urandom_range(0, 31)), 1'b0);
		// square complete: both are ignored
		send_item(pcf_pkg::OP_KEY, 5'd3, 1'b0);
		send_item(pcf_pkg::OP_FINISH, 5'd17, 1'b1);
	endtask

	// Field extremes and the padding and pairing corner cases
	task automatic test_directed_text();
		send_item(pcf_pkg::OP_ENCRYPT, 5'd0, 1'b0);
		send_item(pcf_pkg::OP_ENCRYPT, 5'd25, 1'b0);
		// odd final letter, out of range
		send_item(pcf_pkg::OP_ENCRYPT, 5'd31, 1'b1);
		// doubled final pair gives four letters
		send_item(pcf_pkg::OP_ENCRYPT, 5'd7, 1'b0);
		send_item(pcf_pkg::OP_ENCRYPT, 5'd7, 1'b1);
		// doubled pair mid message
		send_item(pcf_pkg::OP_ENCRYPT, 5'd4, 1'b0);
		send_item(pcf_pkg::OP_ENCRYPT, 5'd4, 1'b0);
		send_item(pcf_pkg::OP_ENCRYPT, 5'd5, 1'b1);
		// X padded with X
		send_item(pcf_pkg::OP_ENCRYPT, pcf_pkg::LETTER_X, 1'b1);
		send_item(pcf_pkg::OP_DECRYPT, pcf_pkg::LETTER_X, 1'b0);
		send_item(pcf_pkg::OP_DECRYPT, pcf_pkg::LETTER_X, 1'b1);
		// odd decrypt length
		send_item(pcf_pkg::OP_DECRYPT, 5'd3, 1'b1);
		// held letter shared across operations
		send_item(pcf_pkg::OP_ENCRYPT, 5'd10, 1'b0);
		send_item(pcf_pkg::OP_DECRYPT, 5'd11, 1'b1);
		// I and J count as a doubled pair
		send_item(pcf_pkg::OP_ENCRYPT, pcf_pkg::LETTER_I, 1'b0);
		send_item(pcf_pkg::OP_ENCRYPT, pcf_pkg::LETTER_J, 1'b1);
	endtask

	// Receiver holds off while the sender keeps pushing, so the block fills
	task automatic test_backpressure();
		no_gaps = 1'b1;
		@(posedge clk);
		hold_req = 300;
		@(negedge clk);
		send_message(pcf_pkg::OP_ENCRYPT, 30);
		no_gaps = 1'b0;
	endtask

	// Mostly well-formed messages, some broken ones and random noise
	task automatic test_random_text();
		int goal, pick, len;
		goal = text_items + 80;
		while (text_items < goal) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				send_message(pcf_pkg::OP_ENCRYPT, $urandom_range(1, 10));
			end else if (pick <= 7) begin
				len = 2 * $urandom_range(1, 5);
				if ($urandom_range(0, 3) == 0)
					len--;
				send_message(pcf_pkg::OP_DECRYPT, len);
			end else begin
				repeat ($urandom_range(1, 4))
					send_item(pcf_pkg::op_t'($urandom_range(0, 3)),
						5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		operation = pcf_pkg::OP_KEY;
		letter = 5'd0;
		last_letter = 1'b0;
		errors = 0;
		text_items = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		hold_req = 0;
		hold_left = 0;
		rx_count = 0;
		rx_mode = 0;
		sq_fill = 0;
		sq_ready = 1'b0;
		hold_ltr = 5'd0;
		hold_ok = 1'b0;
		for (int i = 0; i < 26; i++)
			sq_used[i] = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_not_ready();
		wait_idle();
		test_key_build();
		wait_idle();
		test_directed_text();
		wait_idle();
		test_backpressure();
		wait_idle();
		test_random_text();
		wait_idle();

		if (errors == 0 && cipher_out_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
